FILE: rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the sorted ring set
// Opcodes, status codes, controller states and the command bus that drives
// the row of storage cells.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int OPC_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STEPS_W  = 16;
    localparam int STATUS_W = 3;

    // input item: opcode, value, steps, padded to whole bytes
    localparam int IN_W       = OPC_W + DATA_W + STEPS_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

    // cells per registered group of the cursor read-out
    localparam int GRP_SIZE = 8;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_MOVE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_EMPTY = 3'd2,
        ST_NOCUR = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_GATHER,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

FILE: rtl/srs_cell.sv
// ----------------------------------------------------------------------------
// srs_cell: one storage cell of the sorted ring set
// Holds one entry, compares it with the broadcast value and takes its
// neighbor's entry when the row shifts on insert or remove.
// ----------------------------------------------------------------------------
module srs_cell
    import srs_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic                     i_live,
    input  logic                     i_at_or_after,
    input  logic                     i_prev_lt,
    input  logic signed [DATA_W-1:0] i_prev_val,
    input  logic signed [DATA_W-1:0] i_next_val,
    output logic signed [DATA_W-1:0] o_val,
    output t_cell_flags              o_flags
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    assign o_val      = r_val;
    assign o_flags.lt = i_live && (r_val < i_cmd.value);
    assign o_flags.eq = i_live && (r_val == i_cmd.value);

    always_comb begin
        n_val = r_val;
        unique case (i_cmd.op)
            CELL_INSERT: begin
                // the first cell not below the new value takes it; later cells shift up
                if (!o_flags.lt) begin
                    n_val = i_prev_lt ? i_cmd.value : i_prev_val;
                end
            end
            CELL_REMOVE: begin
                if (i_at_or_after) begin
                    n_val = i_next_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: rtl/srs_mod.sv
// ----------------------------------------------------------------------------
// srs_mod: serial remainder unit
// Restoring division of the step count by the entry count, one quotient
// bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module srs_mod
    import srs_pkg::*;
#(
    parameter int CW = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [STEPS_W-1:0] i_dividend,
    input  logic [CW-1:0]      i_divisor,
    output logic               o_done,
    output logic [CW-1:0]      o_rem
);

    localparam int CNT_W = $clog2(STEPS_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [STEPS_W-1:0] r_dvd;
    logic [CW-1:0]      r_div;
    logic [CW-1:0]      r_rem;
    logic [CW:0]        w_trial;
    logic [CW:0]        w_diff;

    assign w_trial = {r_rem, r_dvd[STEPS_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign o_done  = r_done;
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[STEPS_W-2:0], 1'b0};
            // subtract when the trial remainder reaches the divisor
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= w_diff[CW-1:0];
            end else begin
                r_rem <= w_trial[CW-1:0];
            end
        end
    end

endmodule

FILE: rtl/sorted_ring_set_with_cursor.sv
// ----------------------------------------------------------------------------
// sorted_ring_set_with_cursor: sorted set of signed values with a ring cursor
// Row of storage cells kept in ascending order, a controller and a serial
// remainder unit for cursor moves.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_axis): one item per operation, tdata carries opcode,
//   value and steps. The block takes one item at a time; tready is high only
//   while no operation is in progress.
//   Output channel (m_axis): exactly one result item per input item, with
//   status, cursor flag, cursor value and entry count.
//   Sequence: insert, clear, remove and a move on an empty set pass through
//   the EXEC, GATHER and EMIT states before the result is registered; a
//   move on a non-empty set also waits in DIV for the 16 one-bit steps of
//   the remainder unit reducing steps modulo the count. Insert and remove
//   shift the whole cell row at once, in the EXEC state.
//   The result sits in an output register, so the next item is accepted
//   while a result waits; a stalled receiver holds the block in its last
//   step until the register frees.
//   Reset: the set is empty and the cursor undefined; no clearing pass is
//   needed, cells past the count are never read.
// ----------------------------------------------------------------------------
module sorted_ring_set_with_cursor
    import srs_pkg::*;
#(
    parameter  int CAPACITY    = 64,
    localparam int CW          = $clog2(CAPACITY + 1),
    localparam int OUT_W       = STATUS_W + 1 + DATA_W + CW,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // opcode, value, steps (from bit 0 up), zero padded
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status, cursor_valid, cursor_value, count (from bit 0 up), zero padded
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int IW     = $clog2(CAPACITY);
    localparam int NG     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NPAD   = NG * GRP_SIZE;

    // controller state
    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_cur, n_cur;
    logic                     r_def, n_def;
    t_status                  r_status, n_status;

    // captured item
    t_op                      r_op;
    logic signed [DATA_W-1:0] r_value;
    logic [STEPS_W-1:0]       r_steps;

    // output register
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic                     r_out_cvalid;
    logic signed [DATA_W-1:0] r_out_value;
    logic [CW-1:0]            r_out_count;

    logic                     w_accept;
    logic                     w_emit;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [CW-1:0]            w_rem;
    logic [CW:0]              w_sum;
    logic [CW:0]              w_wrap;
    logic [CW-1:0]            w_count_dec;
    t_cell_cmd                w_cmd;

    logic signed [DATA_W-1:0] w_val    [CAPACITY];
    t_cell_flags              w_flags  [CAPACITY];
    logic [CAPACITY-1:0]      w_lt;
    logic [CAPACITY-1:0]      w_eq;
    logic [CAPACITY-1:0]      w_sel;
    logic                     w_any_eq;
    logic                     w_lt_cur;
    logic [DATA_W-1:0]        w_masked [NPAD];
    logic [DATA_W-1:0]        w_grp    [NG];
    logic [DATA_W-1:0]        r_grp    [NG];
    logic [DATA_W-1:0]        w_gathered;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // ---------------- cell row ----------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                     w_prev_lt;
        logic signed [DATA_W-1:0] w_prev_val;
        logic signed [DATA_W-1:0] w_next_val;

        if (i == 0) begin : g_head
            assign w_prev_lt  = 1'b1;
            assign w_prev_val = '0;
        end else begin : g_body
            assign w_prev_lt  = w_lt[i-1];
            assign w_prev_val = w_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next_val = w_val[i];
        end else begin : g_inner
            assign w_next_val = w_val[i+1];
        end

        srs_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_live        (r_count > CW'(i)),
            .i_at_or_after (IW'(i) >= r_cur),
            .i_prev_lt     (w_prev_lt),
            .i_prev_val    (w_prev_val),
            .i_next_val    (w_next_val),
            .o_val         (w_val[i]),
            .o_flags       (w_flags[i])
        );

        assign w_lt[i]  = w_flags[i].lt;
        assign w_eq[i]  = w_flags[i].eq;
        assign w_sel[i] = (r_cur == IW'(i));
    end

    assign w_any_eq = |w_eq;
    assign w_lt_cur = |(w_lt & w_sel);

    // ---------------- cursor read-out ----------------
    for (genvar i = 0; i < NPAD; i++) begin : g_mask
        if (i < CAPACITY) begin : g_real
            assign w_masked[i] = w_sel[i] ? w_val[i] : '0;
        end else begin : g_pad
            assign w_masked[i] = '0;
        end
    end

    for (genvar g = 0; g < NG; g++) begin : g_group
        always_comb begin
            w_grp[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                w_grp[g] = w_grp[g] | w_masked[g*GRP_SIZE + k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_grp[g] <= w_grp[g];
        end
    end

    always_comb begin
        w_gathered = '0;
        for (int g = 0; g < NG; g++) begin
            w_gathered = w_gathered | r_grp[g];
        end
    end

    // ---------------- remainder unit ----------------
    srs_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_steps),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign w_sum       = {1'b0, CW'(r_cur)} + {1'b0, w_rem};
    assign w_wrap      = (w_sum >= {1'b0, r_count}) ? (w_sum - {1'b0, r_count}) : w_sum;
    assign w_count_dec = r_count - 1'b1;

    // ---------------- controller ----------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_def       = r_def;
        n_status    = r_status;
        w_cmd.op    = CELL_HOLD;
        w_cmd.value = r_value;
        w_div_start = 1'b0;
        w_emit      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_GATHER;
                unique case (r_op)
                    OP_INSERT: begin
                        if (w_any_eq) begin
                            n_status = ST_DUP;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            w_cmd.op = CELL_INSERT;
                            n_count  = r_count + 1'b1;
                            // new entry lands at or below the cursor: follow its entry
                            if (r_def && !w_lt_cur) begin
                                n_cur = r_cur + 1'b1;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        n_status = (r_count == '0) ? ST_EMPTY : ST_OK;
                        n_count  = '0;
                        n_cur    = '0;
                        n_def    = 1'b0;
                    end
                    OP_REMOVE: begin
                        if (!r_def) begin
                            n_status = ST_NOCUR;
                        end else if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_status = ST_OK;
                            w_cmd.op = CELL_REMOVE;
                            n_count  = w_count_dec;
                            if (w_count_dec == '0) begin
                                n_def = 1'b0;
                                n_cur = '0;
                            end else if (CW'(r_cur) >= w_count_dec) begin
                                n_cur = '0;
                            end
                        end
                    end
                    OP_MOVE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_status    = ST_OK;
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                            if (!r_def) begin
                                n_def = 1'b1;
                                n_cur = '0;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_cur   = w_wrap[IW-1:0];
                    n_state = S_GATHER;
                end
            end
            S_GATHER: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cur   <= '0;
            r_def   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_def   <= n_def;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (w_accept) begin
            r_op    <= t_op'(i_s_axis_tdata[OPC_W-1:0]);
            r_value <= i_s_axis_tdata[OPC_W +: DATA_W];
            r_steps <= i_s_axis_tdata[OPC_W+DATA_W +: STEPS_W];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= r_status;
            r_out_cvalid <= r_def;
            r_out_value  <= r_def ? w_gathered : '0;
            r_out_count  <= r_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_value, r_out_cvalid, r_out_status});

endmodule

FILE: rtl/srs_checker.sv
// ----------------------------------------------------------------------------
// srs_checker: port-level checks for the sorted ring set
// Watches the stream channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module srs_checker
    import srs_pkg::*;
#(
    parameter  int CAPACITY    = 64,
    localparam int CW          = $clog2(CAPACITY + 1),
    localparam int OUT_W       = STATUS_W + 1 + DATA_W + CW,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic [STATUS_W-1:0] w_status;
    logic                w_cvalid;
    logic [DATA_W-1:0]   w_cvalue;
    logic [CW-1:0]       w_count;

    assign w_status = o_m_axis_tdata[STATUS_W-1:0];
    assign w_cvalid = o_m_axis_tdata[STATUS_W];
    assign w_cvalue = o_m_axis_tdata[STATUS_W+1 +: DATA_W];
    assign w_count  = o_m_axis_tdata[STATUS_W+1+DATA_W +: CW];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item taken while one is in progress");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_cvalid |-> w_cvalue == '0)
        else $error("cursor value nonzero with cursor undefined");

    a_empty_nocursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_count == '0) |-> !w_cvalid)
        else $error("cursor defined on an empty set");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_status <= STATUS_W'(ST_FULL))
        else $error("status code out of range");

endmodule

bind sorted_ring_set_with_cursor srs_checker #(.CAPACITY(CAPACITY)) u_srs_checker (.*);
